/* rtl/core/ssbm_pkg.sv */
package ssbm_pkg;

	localparam logic [7:0] SW_LAST_BANKING = 8'h0b;
	localparam logic [7:0] SW_DISPLAY_FIRST = 8'h54;
	localparam logic [7:0] SW_DISPLAY_LAST = 8'h57;
	localparam logic [3:0] SW_STATUS_ROW = 4'h1;
	localparam logic [3:0] SW_LANG_CARD_ROW = 4'h8;

	localparam logic [7:0] PAGE_IO_FIRST = 8'hc0;
	localparam logic [7:0] PAGE_SLOT3 = 8'hc3;
	localparam logic [7:0] PAGE_EXP_ROM = 8'hc8;
	localparam logic [7:0] PAGE_HIGH_RAM = 8'hd0;
	localparam logic [7:0] PAGE_BANK_END = 8'he0;

	localparam logic [15:0] ROM_BASE = 16'hc000;
	localparam logic [15:0] BANK1_SHIFT = 16'h1000;

	localparam logic FUNC_SWITCH = 1'b0;
	localparam logic FUNC_TRANSLATE = 1'b1;

	typedef enum logic [2:0] {
		TGT_MAIN = 3'd0,
		TGT_AUX  = 3'd1,
		TGT_SYS  = 3'd2,
		TGT_SLOT = 3'd3,
		TGT_NULL = 3'd4
	} target_t;

	typedef struct packed {
		logic hramwrt;
		logic hramrd;
		logic bank2;
		logic hires;
		logic page2;
		logic slotc3rom;
		logic altzp;
		logic intcxrom;
		logic ramwrt;
		logic ramrd;
		logic store80;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{
		hramwrt: 1'b1, hramrd: 1'b0, bank2: 1'b1, hires: 1'b0, page2: 1'b0,
		slotc3rom: 1'b0, altzp: 1'b0, intcxrom: 1'b0, ramwrt: 1'b0, ramrd: 1'b0,
		store80: 1'b0
	};

	typedef struct packed {
		logic        func;
		logic [15:0] address;
		logic        write;
	} req_t;

	typedef struct packed {
		target_t     target;
		logic [15:0] phys_offset;
		logic        status_bit;
		logic        status_valid;
	} res_t;

endpackage

/* rtl/core/ssbm_if.sv */
interface ssbm_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] address;
	logic        write;

	modport source(output valid, func, address, write, input ready);
	modport sink(input valid, func, address, write, output ready);
endinterface

interface ssbm_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  target;
	logic [15:0] phys_offset;
	logic        status_bit;
	logic        status_valid;

	modport source(output valid, target, phys_offset, status_bit, status_valid, input ready);
	modport sink(input valid, target, phys_offset, status_bit, status_valid, output ready);
endinterface

/* rtl/core/ssbm_switch_regs.sv */
module ssbm_switch_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            update,
	input  ssbm_pkg::req_t  req,
	output ssbm_pkg::flags_t flags
);

	ssbm_pkg::flags_t flags_q;
	ssbm_pkg::flags_t flags_d;
	logic             prewrite_q;
	logic             prewrite_d;
	logic [7:0]       lo;

	assign lo = req.address[7:0];
	assign flags = flags_q;

	always_comb begin
		flags_d = flags_q;
		prewrite_d = prewrite_q;
		if (req.func == ssbm_pkg::FUNC_SWITCH) begin
			if (lo <= ssbm_pkg::SW_LAST_BANKING) begin
				if (req.write) begin
					// even address clears, odd sets
					case (lo[3:1])
						3'd0: flags_d.store80 = lo[0];
						3'd1: flags_d.ramrd = lo[0];
						3'd2: flags_d.ramwrt = lo[0];
						3'd3: flags_d.intcxrom = lo[0];
						3'd4: flags_d.altzp = lo[0];
						3'd5: flags_d.slotc3rom = lo[0];
						default: ;
					endcase
				end
			end else if (lo[7:4] == ssbm_pkg::SW_STATUS_ROW) begin
				// status reads leave the flags alone
			end else if (lo >= ssbm_pkg::SW_DISPLAY_FIRST && lo <= ssbm_pkg::SW_DISPLAY_LAST) begin
				if (lo[1]) begin
					flags_d.hires = lo[0];
				end else begin
					flags_d.page2 = lo[0];
				end
			end else if (lo[7:4] == ssbm_pkg::SW_LANG_CARD_ROW) begin
				flags_d.hramrd = (lo[0] == lo[1]);
				// two odd reads in a row enable high ram writes
				if (lo[0] && !req.write) begin
					if (prewrite_q) begin
						flags_d.hramwrt = 1'b1;
					end
					prewrite_d = 1'b1;
				end else begin
					prewrite_d = 1'b0;
				end
				if (!lo[0]) begin
					flags_d.hramwrt = 1'b0;
				end
				flags_d.bank2 = !lo[3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= ssbm_pkg::FLAGS_RESET;
			prewrite_q <= 1'b0;
		end else if (update) begin
			flags_q <= flags_d;
			prewrite_q <= prewrite_d;
		end
	end

endmodule

/* rtl/core/ssbm_translate.sv */
module ssbm_translate (
	input  ssbm_pkg::req_t   req,
	input  ssbm_pkg::flags_t flags,
	output ssbm_pkg::res_t   res
);

	logic [7:0]        page;
	logic [7:0]        lo;
	ssbm_pkg::target_t zp_tgt;
	ssbm_pkg::target_t low_tgt;
	ssbm_pkg::target_t disp_tgt;
	logic              hram_en;

	assign page = req.address[15:8];
	assign lo = req.address[7:0];
	assign zp_tgt = flags.altzp ? ssbm_pkg::TGT_AUX : ssbm_pkg::TGT_MAIN;
	assign low_tgt = (req.write ? flags.ramwrt : flags.ramrd) ?
		ssbm_pkg::TGT_AUX : ssbm_pkg::TGT_MAIN;
	assign disp_tgt = flags.page2 ? ssbm_pkg::TGT_AUX : ssbm_pkg::TGT_MAIN;
	assign hram_en = req.write ? flags.hramwrt : flags.hramrd;

	always_comb begin
		res.target = ssbm_pkg::TGT_MAIN;
		res.phys_offset = '0;
		res.status_bit = 1'b0;
		res.status_valid = 1'b0;
		if (req.func == ssbm_pkg::FUNC_TRANSLATE) begin
			res.phys_offset = req.address;
			if (page < 8'h02) begin
				res.target = zp_tgt;
			end else if (page >= 8'h04 && page < 8'h08) begin
				res.target = flags.store80 ? disp_tgt : low_tgt;
			end else if (page >= 8'h20 && page < 8'h40) begin
				res.target = (flags.store80 && flags.hires) ? disp_tgt : low_tgt;
			end else if (page < ssbm_pkg::PAGE_IO_FIRST) begin
				res.target = low_tgt;
			end else if (page < ssbm_pkg::PAGE_HIGH_RAM) begin
				if (req.write) begin
					res.target = ssbm_pkg::TGT_NULL;
					res.phys_offset = {8'h00, lo};
				end else begin
					res.phys_offset = req.address - ssbm_pkg::ROM_BASE;
					if (flags.intcxrom || page >= ssbm_pkg::PAGE_EXP_ROM) begin
						res.target = ssbm_pkg::TGT_SYS;
					end else if (page == ssbm_pkg::PAGE_SLOT3 && !flags.slotc3rom) begin
						res.target = ssbm_pkg::TGT_SYS;
					end else begin
						res.target = ssbm_pkg::TGT_SLOT;
					end
				end
			end else begin
				if (hram_en) begin
					res.target = zp_tgt;
					// bank 1 of the $d000 window sits $1000 lower
					if (page < ssbm_pkg::PAGE_BANK_END && !flags.bank2) begin
						res.phys_offset = req.address - ssbm_pkg::BANK1_SHIFT;
					end
				end else if (req.write) begin
					res.target = ssbm_pkg::TGT_NULL;
					res.phys_offset = {8'h00, lo};
				end else begin
					res.target = ssbm_pkg::TGT_SYS;
					res.phys_offset = req.address - ssbm_pkg::ROM_BASE;
				end
			end
		end else if (lo[7:4] == ssbm_pkg::SW_STATUS_ROW && !req.write) begin
			res.status_valid = 1'b1;
			case (lo[3:0])
				4'h1: res.status_bit = flags.bank2;
				4'h2: res.status_bit = flags.hramrd;
				4'h3: res.status_bit = flags.ramrd;
				4'h4: res.status_bit = flags.ramwrt;
				4'h5: res.status_bit = flags.intcxrom;
				4'h6: res.status_bit = flags.altzp;
				4'h7: res.status_bit = flags.slotc3rom;
				4'h8: res.status_bit = flags.store80;
				4'hc: res.status_bit = flags.page2;
				4'hd: res.status_bit = flags.hires;
				default: res.status_valid = 1'b0;
			endcase
		end
	end

endmodule

/* rtl/core/soft_switch_bank_mapper_unit.sv */
// two register stages; throughput: one transaction per cycle while downstream is ready;
// input register feeds translation and flag update logic, result register holds
// the answer while downstream stalls
// flags change as a transaction leaves the input register, so every access sees
// all earlier switch updates; reset sets bank2 and hramwrt, clears the rest
module soft_switch_bank_mapper_unit (
	input logic         clk,
	input logic         arst_n,
	ssbm_in_if.sink     upstream,
	ssbm_out_if.source  downstream
);

	ssbm_pkg::req_t   req_s1;
	logic             valid_s1;
	ssbm_pkg::res_t   res_s2;
	logic             valid_s2;
	ssbm_pkg::flags_t flags;
	ssbm_pkg::res_t   res_comb;
	logic             adv_s2;
	logic             adv_s1;

	assign adv_s2 = !valid_s2 || downstream.ready;
	assign adv_s1 = valid_s1 && adv_s2;
	assign upstream.ready = !valid_s1 || adv_s2;

	ssbm_switch_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.update (adv_s1),
		.req    (req_s1),
		.flags  (flags)
	);

	ssbm_translate u_xlate (
		.req   (req_s1),
		.flags (flags),
		.res   (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (upstream.ready) begin
				valid_s1 <= upstream.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upstream.valid && upstream.ready) begin
			req_s1 <= '{func: upstream.func, address: upstream.address, write: upstream.write};
		end
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign downstream.valid = valid_s2;
	assign downstream.target = res_s2.target;
	assign downstream.phys_offset = res_s2.phys_offset;
	assign downstream.status_bit = res_s2.status_bit;
	assign downstream.status_valid = res_s2.status_valid;

endmodule

/* tb/sv/tb_soft_switch_bank_mapper_unit.sv */
module tb_soft_switch_bank_mapper_unit;
	import ssbm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS = 200;
	localparam int HOLD_CYCLES = 120;

	// status read addresses, low byte
	localparam logic [7:0] ST_KBD_STROBE = 8'h10;
	localparam logic [7:0] ST_BANK2 = 8'h11;
	localparam logic [7:0] ST_HRAMRD = 8'h12;
	localparam logic [7:0] ST_RAMRD = 8'h13;
	localparam logic [7:0] ST_RAMWRT = 8'h14;
	localparam logic [7:0] ST_INTCXROM = 8'h15;
	localparam logic [7:0] ST_ALTZP = 8'h16;
	localparam logic [7:0] ST_SLOTC3 = 8'h17;
	localparam logic [7:0] ST_STORE80 = 8'h18;
	localparam logic [7:0] ST_PAGE2 = 8'h1c;
	localparam logic [7:0] ST_HIRES = 8'h1d;

	// switch addresses used by the directed part
	localparam logic [7:0] SW_STORE80_ON = 8'h01;
	localparam logic [7:0] SW_RAMWRT_ON = 8'h05;
	localparam logic [7:0] SW_INTCX_ON = 8'h07;
	localparam logic [7:0] SW_ALTZP_ON = 8'h09;
	localparam logic [7:0] SW_PAGE2_ON = 8'h55;
	localparam logic [7:0] SW_HIRES_ON = 8'h57;
	localparam logic [7:0] LC_BANK2_RAM_RD = 8'h80;
	localparam logic [7:0] LC_BANK1_RAM_RW = 8'h8b;
	localparam logic [7:0] IO_PAGE = 8'hc0;

	logic clk = 1'b0;
	logic arst_n;

	ssbm_in_if  req_bus();
	ssbm_out_if res_bus();

	soft_switch_bank_mapper_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.upstream  (req_bus),
		.downstream(res_bus)
	);

	always #10 clk = ~clk;

	flags_t bank_flags;
	logic   prewrite_armed;
	res_t   expected_q[$];
	int     fail_count = 0;
	int     idle_cycles = 0;
	int     sink_hold = 0;
	int     sink_pause = 0;
	bit     src_steady = 1'b0;
	bit     sink_steady = 1'b0;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// computes the result of one access and advances the flag state
	function automatic res_t map_access(req_t r);
		res_t       o;
		logic [7:0] page;
		logic [7:0] lo;
		target_t    zp_bank;
		target_t    low_bank;
		target_t    disp_bank;
		logic       ram_sel;

		o = '0;
		o.target = TGT_MAIN;
		if (r.func == FUNC_TRANSLATE) begin
			page = r.address[15:8];
			zp_bank = bank_flags.altzp ? TGT_AUX : TGT_MAIN;
			low_bank = (r.write ? bank_flags.ramwrt : bank_flags.ramrd) ? TGT_AUX : TGT_MAIN;
			disp_bank = bank_flags.page2 ? TGT_AUX : TGT_MAIN;
			o.phys_offset = r.address;
			if (page < 8'h02) begin
				o.target = zp_bank;
			end else if (page >= 8'h04 && page < 8'h08) begin
				o.target = bank_flags.store80 ? disp_bank : low_bank;
			end else if (page >= 8'h20 && page < 8'h40) begin
				o.target = (bank_flags.store80 && bank_flags.hires) ? disp_bank : low_bank;
			end else if (page < PAGE_IO_FIRST) begin
				o.target = low_bank;
			end else if (page < PAGE_HIGH_RAM) begin
				if (r.write) begin
					o.target = TGT_NULL;
					o.phys_offset = {8'h00, r.address[7:0]};
				end else begin
					o.phys_offset = r.address - ROM_BASE;
					if (bank_flags.intcxrom || page >= PAGE_EXP_ROM)
						o.target = TGT_SYS;
					else if (page == PAGE_SLOT3 && !bank_flags.slotc3rom)
						o.target = TGT_SYS;
					else
						o.target = TGT_SLOT;
				end
			end else begin
				ram_sel = r.write ? bank_flags.hramwrt : bank_flags.hramrd;
				if (ram_sel) begin
					o.target = zp_bank;
					if (page < PAGE_BANK_END && !bank_flags.bank2)
						o.phys_offset = r.address - BANK1_SHIFT;
				end else if (r.write) begin
					o.target = TGT_NULL;
					o.phys_offset = {8'h00, r.address[7:0]};
				end else begin
					o.target = TGT_SYS;
					o.phys_offset = r.address - ROM_BASE;
				end
			end
		end else begin
			lo = r.address[7:0];
			if (lo <= SW_LAST_BANKING) begin
				// pairs of addresses map onto the six low flag bits, odd sets
				if (r.write)
					bank_flags[lo[3:1]] = lo[0];
			end else if (lo[7:4] == SW_STATUS_ROW) begin
				if (!r.write) begin
					o.status_valid = 1'b1;
					case (lo)
						ST_BANK2:    o.status_bit = bank_flags.bank2;
						ST_HRAMRD:   o.status_bit = bank_flags.hramrd;
						ST_RAMRD:    o.status_bit = bank_flags.ramrd;
						ST_RAMWRT:   o.status_bit = bank_flags.ramwrt;
						ST_INTCXROM: o.status_bit = bank_flags.intcxrom;
						ST_ALTZP:    o.status_bit = bank_flags.altzp;
						ST_SLOTC3:   o.status_bit = bank_flags.slotc3rom;
						ST_STORE80:  o.status_bit = bank_flags.store80;
						ST_PAGE2:    o.status_bit = bank_flags.page2;
						ST_HIRES:    o.status_bit = bank_flags.hires;
						default:     o.status_valid = 1'b0;
					endcase
				end
			end else if (lo >= SW_DISPLAY_FIRST && lo <= SW_DISPLAY_LAST) begin
				if (lo[1])
					bank_flags.hires = lo[0];
				else
					bank_flags.page2 = lo[0];
			end else if (lo[7:4] == SW_LANG_CARD_ROW) begin
				bank_flags.hramrd = (lo[0] == lo[1]);
				// two odd reads in a row enable high ram writes
				if (lo[0] && !r.write) begin
					if (prewrite_armed)
						bank_flags.hramwrt = 1'b1;
					prewrite_armed = 1'b1;
				end else begin
					prewrite_armed = 1'b0;
				end
				if (!lo[0])
					bank_flags.hramwrt = 1'b0;
				bank_flags.bank2 = !lo[3];
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic send_access(input logic fn, input logic [15:0] addr, input logic wr);
		req_t r;
		int   gap;

		r.func = fn;
		r.address = addr;
		r.write = wr;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.func <= r.func;
		req_bus.address <= r.address;
		req_bus.write <= r.write;
		do
			@(posedge clk);
		while (!req_bus.ready);
		expected_q.push_back(map_access(r));
	endtask

	task automatic wait_results_drained();
		req_bus.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_switch_address();
		logic [15:0] addr;

		addr = 16'($urandom);
		case ($urandom_range(0, 9))
			0, 1:    addr[7:0] = 8'($urandom_range(0, 11));
			2, 3:    addr[7:0] = {SW_STATUS_ROW, 4'($urandom_range(0, 15))};
			4:       addr[7:0] = SW_DISPLAY_FIRST + 8'($urandom_range(0, 3));
			5, 6:    addr[7:0] = {SW_LANG_CARD_ROW, 4'($urandom_range(0, 15))};
			default: ;
		endcase
		return addr;
	endfunction

	task automatic test_directed();
		send_access(FUNC_SWITCH, {8'hff, ST_BANK2}, 1'b0);
		send_access(FUNC_SWITCH, {IO_PAGE, ST_BANK2}, 1'b1);
		send_access(FUNC_SWITCH, {IO_PAGE, ST_KBD_STROBE}, 1'b0);
		// reads of the banking switches leave the flags alone
		send_access(FUNC_SWITCH, {IO_PAGE, SW_STORE80_ON}, 1'b0);
		send_access(FUNC_SWITCH, {IO_PAGE, ST_STORE80}, 1'b0);
		send_access(FUNC_SWITCH, {IO_PAGE, SW_STORE80_ON}, 1'b1);
		send_access(FUNC_SWITCH, {IO_PAGE, SW_PAGE2_ON}, 1'b1);
		send_access(FUNC_TRANSLATE, 16'h0400, 1'b0);
		send_access(FUNC_TRANSLATE, 16'h2000, 1'b1);
		send_access(FUNC_SWITCH, {IO_PAGE, SW_HIRES_ON}, 1'b0);
		send_access(FUNC_TRANSLATE, 16'h3fff, 1'b1);
		send_access(FUNC_SWITCH, {IO_PAGE, SW_RAMWRT_ON}, 1'b1);
		send_access(FUNC_TRANSLATE, 16'h8000, 1'b1);
		send_access(FUNC_TRANSLATE, 16'hbfff, 1'b0);
		send_access(FUNC_SWITCH, {IO_PAGE, SW_ALTZP_ON}, 1'b1);
		send_access(FUNC_TRANSLATE, 16'h0000, 1'b0);
		send_access(FUNC_TRANSLATE, 16'hc300, 1'b0);
		send_access(FUNC_TRANSLATE, 16'hc7ff, 1'b0);
		send_access(FUNC_TRANSLATE, 16'hc0ff, 1'b1);
		send_access(FUNC_SWITCH, {IO_PAGE, LC_BANK2_RAM_RD}, 1'b0);
		send_access(FUNC_TRANSLATE, 16'hd000, 1'b1);
		send_access(FUNC_SWITCH, {IO_PAGE, LC_BANK1_RAM_RW}, 1'b0);
		send_access(FUNC_SWITCH, {IO_PAGE, LC_BANK1_RAM_RW}, 1'b0);
		send_access(FUNC_TRANSLATE, 16'hd123, 1'b1);
		send_access(FUNC_TRANSLATE, 16'hffff, 1'b0);
		send_access(FUNC_SWITCH, {IO_PAGE, SW_INTCX_ON}, 1'b1);
		send_access(FUNC_TRANSLATE, 16'hc500, 1'b0);
		wait_results_drained();
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1))
				send_access(FUNC_TRANSLATE, 16'($urandom), 1'($urandom));
			else
				send_access(FUNC_SWITCH, pick_switch_address(), 1'($urandom));
		end
		wait_results_drained();
	endtask

	// double reads to enable writes, then traffic into the high ram window
	task automatic test_lang_card_sequences(input int count);
		int          sent;
		logic [7:0]  lo;
		logic [15:0] addr;

		sent = 0;
		while (sent < count) begin
			lo = {SW_LANG_CARD_ROW, 4'($urandom_range(0, 15))};
			addr = {8'($urandom), lo};
			if ($urandom_range(0, 3) != 0) begin
				lo[0] = 1'b1;
				addr[7:0] = lo;
				send_access(FUNC_SWITCH, addr, 1'b0);
				// now and then break the pair with a write
				send_access(FUNC_SWITCH, addr, ($urandom_range(0, 4) == 0));
			end else begin
				send_access(FUNC_SWITCH, addr, 1'($urandom));
			end
			sent += 2;
			repeat ($urandom_range(1, 3)) begin
				addr = 16'($urandom);
				addr[15:12] = 4'($urandom_range(13, 15));
				send_access(FUNC_TRANSLATE, addr, 1'($urandom));
				sent++;
			end
		end
		wait_results_drained();
	endtask

	task automatic test_backpressure(input int count);
		src_steady = 1'b1;
		sink_hold = HOLD_CYCLES;
		test_random_mix(count);
		src_steady = 1'b0;
	endtask

	task automatic test_steady_stream(input int count);
		src_steady = 1'b1;
		sink_steady = 1'b1;
		test_random_mix(count);
		src_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	// receiver side: long hold when asked, always ready when steady, random stalls otherwise
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			res_bus.ready <= 1'b0;
			sink_hold--;
		end else if (sink_steady) begin
			res_bus.ready <= 1'b1;
		end else if (sink_pause > 0) begin
			res_bus.ready <= 1'b0;
			sink_pause--;
		end else begin
			res_bus.ready <= 1'b1;
			sink_pause = pick_gap();
		end
	end

	always @(posedge clk) begin
		res_t want;

		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with no transaction outstanding");
			end else begin
				want = expected_q.pop_front();
				if (res_bus.target !== want.target ||
						res_bus.phys_offset !== want.phys_offset ||
						res_bus.status_bit !== want.status_bit ||
						res_bus.status_valid !== want.status_valid)
					report_mismatch($sformatf(
						"target %0d/%0d offset %h/%h status_bit %b/%b status_valid %b/%b",
						res_bus.target, want.target, res_bus.phys_offset, want.phys_offset,
						res_bus.status_bit, want.status_bit, res_bus.status_valid,
						want.status_valid));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_soft_switch_bank_mapper_unit failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.func <= FUNC_SWITCH;
		req_bus.address <= '0;
		req_bus.write <= 1'b0;
		bank_flags = '0;
		bank_flags.bank2 = 1'b1;
		bank_flags.hramwrt = 1'b1;
		prewrite_armed = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(650);
		test_lang_card_sequences(260);
		test_backpressure(60);
		test_steady_stream(150);

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_soft_switch_bank_mapper_unit passed");
		else
			$display("tb_soft_switch_bank_mapper_unit failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ssbm_pkg.sv
rtl/core/ssbm_if.sv
rtl/core/ssbm_switch_regs.sv
rtl/core/ssbm_translate.sv
rtl/core/soft_switch_bank_mapper_unit.sv
tb/sv/tb_soft_switch_bank_mapper_unit.sv
